>>> design/ktst_pkg.sv
// shared types, constants and key helpers for the keyed top-k score table
`default_nettype none

package ktst_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int KEY_BYTES     = 15;

  localparam int LOW_W   = 64;
  localparam int HIGH_W  = 56;
  localparam int KEY_W   = LOW_W + HIGH_W;
  localparam int ATTR_W  = 16;
  localparam int SCORE_W = 19;
  localparam int ATTRS   = 5;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef struct packed {
    key_t   key;
    score_t score;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // name ends at the first zero byte, and nothing past KEY_BYTES survives
  function automatic key_t normalize_key(input logic [LOW_W-1:0] lo,
                                         input logic [HIGH_W-1:0] hi);
    key_t raw;
    key_t res;
    logic ended;
    raw   = {hi, lo};
    res   = '0;
    ended = 1'b0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (b < KEY_BYTES && !ended && raw[8*b +: 8] != 8'd0) begin
        res[8*b +: 8] = raw[8*b +: 8];
      end else begin
        ended = 1'b1;
      end
    end
    return res;
  endfunction

  // "Vazio", cut to the key width
  localparam key_t EMPTY_KEY = normalize_key(64'h0000_006F_697A_6156, 56'd0);

  localparam entry_t EMPTY_ENTRY = '{key: EMPTY_KEY, score: '0};

endpackage

`default_nettype wire

>>> design/ktst_in_if.sv
// request channel carrying one key and its five attributes
`default_nettype none

interface ktst_in_if;
  import ktst_pkg::*;

  logic              valid;
  logic              ready;
  logic [LOW_W-1:0]  key_low;
  logic [HIGH_W-1:0] key_high;
  logic [ATTR_W-1:0] stamina;
  logic [ATTR_W-1:0] motivation;
  logic [ATTR_W-1:0] reputation;
  logic [ATTR_W-1:0] wisdom;
  logic [ATTR_W-1:0] grade;

  modport source (
    output valid, key_low, key_high, stamina, motivation, reputation, wisdom, grade,
    input  ready
  );

  modport sink (
    input  valid, key_low, key_high, stamina, motivation, reputation, wisdom, grade,
    output ready
  );

endinterface

`default_nettype wire

>>> design/ktst_out_if.sv
// result channel carrying the table-changed flag
`default_nettype none

interface ktst_out_if;

  logic valid;
  logic ready;
  logic changed;

  modport source (
    output valid, changed,
    input  ready
  );

  modport sink (
    input  valid, changed,
    output ready
  );

endinterface

`default_nettype wire

>>> design/ktst_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module ktst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> design/keyed_top_k_score_table.sv
// top level: sequencer that keeps the sorted top-k table of name keys and scores
//
// Keeps a table of TABLE_ENTRIES (name, score) pairs sorted by descending score,
// all reset to ("Vazio", 0). Each request is taken only while the block is idle;
// the five attributes are summed one per cycle on a shared adder, then the
// table ram is walked one entry at a time with one key and score compare unit
// to find the first matching name and the insertion slot. A known name with a
// higher score is removed (entries below move up) and reinserted; a new name
// goes in if it beats the last entry. Every entry move is a ram read followed
// by a ram write, so the single table ram sets the latency, which is shortest
// when the table is unchanged and longest when the top entry is removed and
// reinserted at the top. A finished result waits in an output register, and
// the next request may be taken while it waits. Entries never written since
// reset read as the empty entry through per-entry valid bits.
`default_nettype none

module keyed_top_k_score_table (
  input wire logic   clk,
  input wire logic   rst_n,
  ktst_in_if.sink    in_ch,
  ktst_out_if.source out_ch
);
  import ktst_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SUM      = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_DECIDE   = 4'd4;
  localparam logic [3:0] S_RM_RD    = 4'd5;
  localparam logic [3:0] S_RM_WR    = 4'd6;
  localparam logic [3:0] S_RM_LAST  = 4'd7;
  localparam logic [3:0] S_INS_RD   = 4'd8;
  localparam logic [3:0] S_INS_WR   = 4'd9;
  localparam logic [3:0] S_INS_NEW  = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  localparam int ADD_W = $clog2(ATTRS - 1);

  logic [3:0] state_r, state_nxt;
  idx_t       idx_r, idx_nxt;
  idx_t       pos_r, pos_nxt;
  idx_t       ins_r, ins_nxt;
  logic       found_r, found_nxt;
  logic       ins_set_r, ins_set_nxt;
  score_t     old_score_r, old_score_nxt;
  key_t       key_r, key_nxt;
  score_t     score_r, score_nxt;
  logic [ATTR_W-1:0] attr_r [ATTRS-1];
  logic [ATTR_W-1:0] attr_nxt [ATTRS-1];
  logic [ADD_W-1:0]  sum_cnt_r, sum_cnt_nxt;
  logic       changed_r, changed_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_changed_r, out_changed_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic       rd_valid_r;

  logic   rd_en;
  idx_t   rd_addr;
  logic   wr_en;
  idx_t   wr_addr;
  entry_t wr_data;
  entry_t rd_data;
  entry_t rd_entry;
  logic   key_match;
  logic   accept;

  ktst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // never-written slots read as the empty entry
  assign rd_entry  = rd_valid_r ? rd_data : EMPTY_ENTRY;
  assign key_match = (rd_entry.key == key_r);

  assign in_ch.ready    = (state_r == S_IDLE);
  assign accept         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.changed = out_changed_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    ins_nxt       = ins_r;
    found_nxt     = found_r;
    ins_set_nxt   = ins_set_r;
    old_score_nxt = old_score_r;
    key_nxt       = key_r;
    score_nxt     = score_r;
    attr_nxt      = attr_r;
    sum_cnt_nxt   = sum_cnt_r;
    changed_nxt   = changed_r;
    valid_nxt     = valid_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = rd_entry;

    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_changed_nxt = out_changed_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt     = normalize_key(in_ch.key_low, in_ch.key_high);
          score_nxt   = SCORE_W'(in_ch.stamina);
          attr_nxt[0] = in_ch.motivation;
          attr_nxt[1] = in_ch.reputation;
          attr_nxt[2] = in_ch.wisdom;
          attr_nxt[3] = in_ch.grade;
          sum_cnt_nxt = '0;
          found_nxt   = 1'b0;
          ins_set_nxt = 1'b0;
          state_nxt   = S_SUM;
        end
      end

      S_SUM: begin
        score_nxt = score_r + SCORE_W'(attr_r[sum_cnt_r]);
        if (sum_cnt_r == ADD_W'(ATTRS - 2)) begin
          idx_nxt   = '0;
          state_nxt = S_SCAN_RD;
        end else begin
          sum_cnt_nxt = sum_cnt_r + 1'b1;
        end
      end

      S_SCAN_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (key_match && !found_r) begin
          found_nxt     = 1'b1;
          pos_nxt       = idx_r;
          old_score_nxt = rd_entry.score;
        end else if (!ins_set_r && score_r > rd_entry.score) begin
          // slot index as seen after the matched entry is taken out
          ins_set_nxt = 1'b1;
          ins_nxt     = found_r ? idx_r - 1'b1 : idx_r;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end

      S_DECIDE: begin
        if (found_r && score_r <= old_score_r) begin
          changed_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else if (found_r) begin
          changed_nxt = 1'b1;
          idx_nxt     = pos_r;
          // after removal the cleared last slot always loses
          if (!ins_set_r) begin
            ins_nxt = LAST_IDX;
          end
          state_nxt = (pos_r == LAST_IDX) ? S_RM_LAST : S_RM_RD;
        end else if (ins_set_r) begin
          changed_nxt = 1'b1;
          idx_nxt     = LAST_IDX;
          state_nxt   = (ins_r == LAST_IDX) ? S_INS_NEW : S_INS_RD;
        end else begin
          changed_nxt = 1'b0;
          state_nxt   = S_DONE;
        end
      end

      S_RM_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r + 1'b1;
        state_nxt = S_RM_WR;
      end

      S_RM_WR: begin
        wr_en              = 1'b1;
        wr_addr            = idx_r;
        wr_data            = rd_entry;
        valid_nxt[idx_r]   = 1'b1;
        idx_nxt            = idx_r + 1'b1;
        state_nxt          = (idx_r + 1'b1 == LAST_IDX) ? S_RM_LAST : S_RM_RD;
      end

      S_RM_LAST: begin
        wr_en               = 1'b1;
        wr_addr             = LAST_IDX;
        wr_data             = EMPTY_ENTRY;
        valid_nxt[LAST_IDX] = 1'b1;
        idx_nxt             = LAST_IDX;
        state_nxt           = (ins_r == LAST_IDX) ? S_INS_NEW : S_INS_RD;
      end

      S_INS_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r - 1'b1;
        state_nxt = S_INS_WR;
      end

      S_INS_WR: begin
        wr_en            = 1'b1;
        wr_addr          = idx_r;
        wr_data          = rd_entry;
        valid_nxt[idx_r] = 1'b1;
        idx_nxt          = idx_r - 1'b1;
        state_nxt        = (idx_r - 1'b1 == ins_r) ? S_INS_NEW : S_INS_RD;
      end

      S_INS_NEW: begin
        wr_en            = 1'b1;
        wr_addr          = ins_r;
        wr_data          = '{key: key_r, score: score_r};
        valid_nxt[ins_r] = 1'b1;
        state_nxt        = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_changed_nxt = changed_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      found_r     <= 1'b0;
      ins_set_r   <= 1'b0;
      sum_cnt_r   <= '0;
      idx_r       <= '0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      ins_set_r   <= ins_set_nxt;
      sum_cnt_r   <= sum_cnt_nxt;
      idx_r       <= idx_nxt;
      changed_r   <= changed_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    ins_r         <= ins_nxt;
    old_score_r   <= old_score_nxt;
    key_r         <= key_nxt;
    score_r       <= score_nxt;
    attr_r        <= attr_nxt;
    out_changed_r <= out_changed_nxt;
  end

endmodule

`default_nettype wire

>>> sim/tb_keyed_top_k_score_table.sv
// testbench for the keyed top-k score table: directed rows, then random requests vs a predictor
`timescale 1ns / 1ps

module tb_keyed_top_k_score_table;
  import ktst_pkg::*;

  localparam int          RAND_ITEMS  = 1050;
  localparam int          POOL_SIZE   = 12;
  localparam int          CYCLE_LIMIT = 500_000;
  localparam int          SETTLE      = 60;
  localparam logic [63:0] VAZIO_LO    = 64'h0000_006F_697A_6156;

  typedef enum logic [1:0] {EXP_UNCHANGED, EXP_CHANGED, EXP_PREDICTED} pin_t;

  typedef struct packed {
    logic [63:0]       lo;
    logic [55:0]       hi;
    logic [4:0][15:0]  at;   // stamina, motivation, reputation, wisdom, grade
    pin_t              pin;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [25] = '{
    '{VAZIO_LO, 56'h0, {5{16'd0}}, EXP_UNCHANGED},
    '{64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, {5{16'hFFFF}}, EXP_CHANGED},
    '{64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, {5{16'hFFFF}}, EXP_UNCHANGED},
    '{64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF,
      {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE}, EXP_UNCHANGED},
    // junk after the zero byte must not count
    '{64'h1122_3344_0055_6677, 56'hFF_FFFF_FFFF_FFFF,
      {16'd1, 16'd0, 16'd0, 16'd0, 16'd0}, EXP_CHANGED},
    '{64'h0000_0000_0055_6677, 56'h0, {16'd0, 16'd0, 16'd0, 16'd0, 16'd1}, EXP_UNCHANGED},
    '{64'h0000_0000_0055_6677, 56'h0, {16'd0, 16'd0, 16'd0, 16'd1, 16'd1}, EXP_CHANGED},
    '{64'h0, 56'h0, {5{16'd0}}, EXP_UNCHANGED},
    '{64'h0, 56'h0, {16'd0, 16'd0, 16'd5, 16'd0, 16'd0}, EXP_CHANGED},
    // empty-slot name with a real score takes out the first empty slot
    '{VAZIO_LO, 56'h0, {16'd10, 16'd0, 16'd0, 16'd0, 16'd0}, EXP_CHANGED},
    '{64'hFFFF_FFFF_FFFF_FF00, 56'hFF_FFFF_FFFF_FFFF,
      {16'd0, 16'd0, 16'd0, 16'd0, 16'd3}, EXP_UNCHANGED},
    '{64'h4141, 56'h0, {16'd1003, 16'd0, 16'd0, 16'd0, 16'd0}, EXP_PREDICTED},
    '{64'h4242, 56'h0, {16'd0, 16'd1000, 16'd0, 16'd0, 16'd0}, EXP_PREDICTED},
    '{64'h4343, 56'h0, {16'd0, 16'd0, 16'd1006, 16'd0, 16'd0}, EXP_PREDICTED},
    '{64'h4444, 56'h0, {16'd0, 16'd0, 16'd0, 16'd1001, 16'd0}, EXP_PREDICTED},
    '{64'h4545, 56'h0, {16'd0, 16'd0, 16'd0, 16'd0, 16'd1005}, EXP_PREDICTED},
    '{64'h4646, 56'h0, {16'd1000, 16'd2, 16'd0, 16'd0, 16'd0}, EXP_PREDICTED},
    '{64'h4747, 56'h0, {16'd1000, 16'd0, 16'd0, 16'd0, 16'd4}, EXP_PREDICTED},
    // table full: tie with the last entry, below it, just above it
    '{64'h4848, 56'h0, {5{16'd200}}, EXP_PREDICTED},
    '{64'h4949, 56'h0, {16'd0, 16'd0, 16'd0, 16'd999, 16'd0}, EXP_PREDICTED},
    '{64'h4A4A, 56'h0, {16'd500, 16'd501, 16'd0, 16'd0, 16'd0}, EXP_PREDICTED},
    '{64'h4343, 56'h0, {5{16'd400}}, EXP_PREDICTED},
    '{VAZIO_LO, 56'h0, {5{16'd10000}}, EXP_PREDICTED},
    '{64'h0102_0304_0506_0708, 56'h0F_0E0D_0C0B_0A09,
      {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE}, EXP_PREDICTED},
    '{64'h0102_0304_0506_0708, 56'h8F_0E0D_0C0B_0A09, {5{16'hFFFF}}, EXP_PREDICTED}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ktst_in_if  req_if ();
  ktst_out_if res_if ();

  keyed_top_k_score_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if)
  );

  always #5 clk = ~clk;

  key_t   rank_key   [TABLE_ENTRIES];
  score_t rank_score [TABLE_ENTRIES];
  key_t   blank_key;

  pin_t pinned_q  [$];
  logic changed_q [$];

  bit calm = 1'b0;
  int cycle_count  = 0;
  int miss_count   = 0;
  int req_count    = 0;
  int result_count = 0;
  int update_count = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // a name stops at its first zero byte and at KEY_BYTES
  function automatic key_t trim_name(input logic [63:0] lo, input logic [55:0] hi);
    key_t raw;
    key_t res;
    bit   stop;
    raw  = {hi, lo};
    res  = '0;
    stop = 1'b0;
    for (int b = 0; b < 15; b++) begin
      if (raw[8*b +: 8] == 8'h00 || b >= KEY_BYTES) stop = 1'b1;
      if (!stop) res[8*b +: 8] = raw[8*b +: 8];
    end
    return res;
  endfunction

  // applies one request to the shadow table, returns whether it changed
  function automatic bit rank_update(input key_t k, input score_t s);
    int hit;
    bit chg;
    bit placed;
    hit    = -1;
    chg    = 1'b0;
    placed = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (hit < 0 && rank_key[i] == k) hit = i;
    if (hit >= 0) begin
      if (s <= rank_score[hit]) return 1'b0;
      for (int i = hit; i < TABLE_ENTRIES - 1; i++) begin
        rank_key[i]   = rank_key[i+1];
        rank_score[i] = rank_score[i+1];
      end
      rank_key[TABLE_ENTRIES-1]   = blank_key;
      rank_score[TABLE_ENTRIES-1] = '0;
      chg = 1'b1;
    end
    if (chg || s > rank_score[TABLE_ENTRIES-1]) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!placed && s > rank_score[i]) begin
          for (int j = TABLE_ENTRIES - 1; j > i; j--) begin
            rank_key[j]   = rank_key[j-1];
            rank_score[j] = rank_score[j-1];
          end
          rank_key[i]   = k;
          rank_score[i] = s;
          placed = 1'b1;
          chg    = 1'b1;
        end
      end
    end
    return chg;
  endfunction

  function automatic void report_miss(input string what, input int exp_v, input int act_v);
    miss_count++;
    if (miss_count <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $time, what, exp_v, act_v);
  endfunction

  // result check first, then the prediction for a request taken at the same edge
  always @(posedge clk) begin : scoreboard
    key_t   k;
    score_t s;
    bit     got;
    pin_t   pin;
    logic   want;
    if (res_if.valid && res_if.ready) begin
      result_count++;
      if (res_if.changed === 1'b1) update_count++;
      if (changed_q.size() == 0) begin
        report_miss("result with no request pending", -1, res_if.changed);
      end else begin
        want = changed_q.pop_front();
        if (res_if.changed !== want) report_miss("changed flag", want, res_if.changed);
      end
    end
    if (req_if.valid && req_if.ready) begin
      req_count++;
      k = trim_name(req_if.key_low, req_if.key_high);
      s = score_t'(req_if.stamina) + score_t'(req_if.motivation) + score_t'(req_if.reputation)
        + score_t'(req_if.wisdom) + score_t'(req_if.grade);
      got = rank_update(k, s);
      pin = pinned_q.pop_front();
      case (pin)
        EXP_UNCHANGED: changed_q.push_back(1'b0);
        EXP_CHANGED:   changed_q.push_back(1'b1);
        default:       changed_q.push_back(got);
      endcase
    end
  end

  task automatic send_req(input logic [63:0] lo, input logic [55:0] hi,
                          input logic [4:0][15:0] at, input pin_t pin);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pinned_q.push_back(pin);
    req_if.valid      <= 1'b1;
    req_if.key_low    <= lo;
    req_if.key_high   <= hi;
    req_if.stamina    <= at[4];
    req_if.motivation <= at[3];
    req_if.reputation <= at[2];
    req_if.wisdom     <= at[1];
    req_if.grade      <= at[0];
    do @(posedge clk); while (!req_if.ready);
  endtask

  // hold off new requests until every pending result is back
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (changed_q.size() != 0) @(posedge clk);
  endtask

  // result side: stall either before the result shows up or after
  initial begin
    int stall;
    bit early;
    res_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      early = calm ? 1'b1 : 1'($urandom_range(0, 1));
      if (!(early && stall == 0)) begin
        res_if.ready <= 1'b0;
        if (!early) begin
          do @(posedge clk); while (!res_if.valid);
        end
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still pending", cycle_count,
             changed_q.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    key_t             pool_key [POOL_SIZE];
    int               pool_len [POOL_SIZE];
    logic [4:0][15:0] pool_at  [POOL_SIZE];
    key_t             raw;
    logic [4:0][15:0] at;
    int               epoch;
    int               cap;
    int               pick;
    int               pk;
    int               tail;

    req_if.valid      = 1'b0;
    req_if.key_low    = '0;
    req_if.key_high   = '0;
    req_if.stamina    = '0;
    req_if.motivation = '0;
    req_if.reputation = '0;
    req_if.wisdom     = '0;
    req_if.grade      = '0;

    blank_key = trim_name(VAZIO_LO, 56'h0);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      rank_key[i]   = blank_key;
      rank_score[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_len[i] = $urandom_range(1, 15);
      pool_key[i] = '0;
      pool_at[i]  = '0;
      for (int b = 0; b < pool_len[i]; b++) pool_key[i][8*b +: 8] = 8'($urandom_range(1, 255));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(DIR_ROWS); i++)
      send_req(DIR_ROWS[i].lo, DIR_ROWS[i].hi, DIR_ROWS[i].at, DIR_ROWS[i].pin);
    drain();

    // score caps grow by epoch so late names still get into the table
    for (int n = 0; n < RAND_ITEMS; n++) begin
      epoch = n / 175;
      cap   = (1 << (6 + 2 * epoch)) - 1;
      calm  = (n % 150) < 30;
      pick  = $urandom_range(0, 99);
      pk    = $urandom_range(0, POOL_SIZE - 1);
      for (int a = 0; a < 5; a++) at[a] = 16'($urandom_range(0, cap));
      raw = pool_key[pk];
      if (pick < 50) begin
        pool_at[pk] = at;
      end else if (pick < 65) begin
        at = pool_at[pk];
      end else if (pick < 73) begin
        at = pool_at[pk];
        if (at[4] != 16'hFFFF) at[4] = at[4] + 16'd1;
        pool_at[pk] = at;
      end else if (pick < 85) begin
        raw  = key_t'({$urandom, $urandom, $urandom, $urandom});
        tail = $urandom_range(0, 19);
        if (tail < 15) raw[8*tail +: 8] = 8'h00;
      end else if (pick < 93) begin
        raw = key_t'(VAZIO_LO);
        if ($urandom_range(0, 1) == 1)
          for (int b = 6; b < 15; b++) raw[8*b +: 8] = 8'($urandom);
        if ($urandom_range(0, 3) == 0) at = '0;
      end else if (pick < 97) begin
        raw = key_t'({$urandom, $urandom, $urandom, $urandom});
        raw[7:0] = 8'h00;
      end else begin
        raw = key_t'({$urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 1) == 1) at = '1;
        else for (int a = 0; a < 5; a++) at[a] = 16'($urandom);
      end
      // pool names sometimes carry junk past the terminator
      if (pick < 73 && pool_len[pk] < 14 && $urandom_range(0, 2) == 0)
        for (int b = pool_len[pk] + 1; b < 15; b++) raw[8*b +: 8] = 8'($urandom);
      send_req(raw[63:0], raw[119:64], at, EXP_PREDICTED);
      if (n % 350 == 349) drain();
    end
    calm = 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d requests (%0d directed, %0d random) in %0d cycles",
             req_count, $size(DIR_ROWS), RAND_ITEMS, cycle_count);
    $display("%0d results checked, %0d of them changed the table", result_count,
             update_count);
    if (miss_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
design/ktst_pkg.sv
design/ktst_in_if.sv
design/ktst_out_if.sv
design/ktst_ram.sv
design/keyed_top_k_score_table.sv
sim/tb_keyed_top_k_score_table.sv
